/* rtl/core/cvs_pkg.sv */
package cvs_pkg;

    localparam int VOLT_W   = 16;
    localparam int SEG_W    = 3;
    localparam int CELL_W   = 4;
    localparam int SEGSUM_W = 21;
    localparam int SEGOUT_W = 20;
    localparam int PACK_W   = 23;
    localparam int CNT_W    = 8;

    localparam logic [SEGSUM_W-1:0] SEGSUM_MAX       = '1;
    localparam logic [SEGOUT_W-1:0] SEGOUT_MAX       = '1;
    localparam logic [PACK_W-1:0]   PACK_MAX         = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX          = '1;
    localparam logic [CNT_W-1:0]    FAIL_LIMIT_RESET = 8'd3;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        logic [SEG_W-1:0]  segment;
        logic [CELL_W-1:0] cell_req;
        logic              read_ok;
        logic              segment_last;
        logic              sweep_last;
    } t_cell_item;

    typedef struct packed {
        logic [SEG_W-1:0]    segment_index;
        logic [SEGOUT_W-1:0] segment_voltage;
        logic                sweep_done;
        logic [PACK_W-1:0]   pack_total;
        logic [VOLT_W-1:0]   min_voltage;
        logic [SEG_W-1:0]    min_segment;
        logic [CELL_W-1:0]   min_cell;
        logic [VOLT_W-1:0]   max_voltage;
        logic [SEG_W-1:0]    max_segment;
        logic [CELL_W-1:0]   max_cell;
        logic [CNT_W-1:0]    fail_count;
        logic                comm_fault;
    } t_stat_item;

    typedef struct packed {
        logic valid;
        logic has_result;
        logic advance;
    } t_stage_ctl;

endpackage

/* rtl/core/cvs_cell_if.sv */
interface cvs_cell_if import cvs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VOLT_W-1:0] voltage;
    logic [SEG_W-1:0]  segment;
    logic [CELL_W-1:0] cell_req;
    logic              read_ok;
    logic              segment_last;
    logic              sweep_last;

    modport source (
        output valid, voltage, segment, cell_req, read_ok, segment_last, sweep_last,
        input  ready
    );

    modport sink (
        input  valid, voltage, segment, cell_req, read_ok, segment_last, sweep_last,
        output ready
    );
endinterface

/* rtl/core/cvs_stat_if.sv */
interface cvs_stat_if import cvs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEG_W-1:0]    segment_index;
    logic [SEGOUT_W-1:0] segment_voltage;
    logic                sweep_done;
    logic [PACK_W-1:0]   pack_total;
    logic [VOLT_W-1:0]   min_voltage;
    logic [SEG_W-1:0]    min_segment;
    logic [CELL_W-1:0]   min_cell;
    logic [VOLT_W-1:0]   max_voltage;
    logic [SEG_W-1:0]    max_segment;
    logic [CELL_W-1:0]   max_cell;
    logic [CNT_W-1:0]    fail_count;
    logic                comm_fault;

    modport source (
        output valid, segment_index, segment_voltage, sweep_done, pack_total,
               min_voltage, min_segment, min_cell, max_voltage, max_segment,
               max_cell, fail_count, comm_fault,
        input  ready
    );

    modport sink (
        input  valid, segment_index, segment_voltage, sweep_done, pack_total,
               min_voltage, min_segment, min_cell, max_voltage, max_segment,
               max_cell, fail_count, comm_fault,
        output ready
    );
endinterface

/* rtl/core/cvs_in_stage.sv */
module cvs_in_stage import cvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_item i_item,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output t_cell_item o_item
);

    logic       r_valid;
    t_cell_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/cvs_tracker.sv */
module cvs_tracker import cvs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_cell_item       i_item,
    input  logic [CNT_W-1:0] i_fail_limit,
    output logic             o_has_result,
    output t_stat_item       o_result
);

    logic [VOLT_W-1:0]   r_low_value;
    logic [SEG_W-1:0]    r_low_segment;
    logic [CELL_W-1:0]   r_low_cell;
    logic [VOLT_W-1:0]   r_high_value;
    logic [SEG_W-1:0]    r_high_segment;
    logic [CELL_W-1:0]   r_high_cell;
    logic [SEGSUM_W-1:0] r_segment_sum;
    logic [PACK_W-1:0]   r_pack_sum;
    logic                r_had_failure;
    logic [CNT_W-1:0]    r_failed_sweeps;
    logic                r_at_start;

    logic [VOLT_W-1:0]   n_low_value;
    logic [SEG_W-1:0]    n_low_segment;
    logic [CELL_W-1:0]   n_low_cell;
    logic [VOLT_W-1:0]   n_high_value;
    logic [SEG_W-1:0]    n_high_segment;
    logic [CELL_W-1:0]   n_high_cell;
    logic [SEGSUM_W-1:0] n_segment_sum;
    logic [PACK_W-1:0]   n_pack_sum;
    logic                n_had_failure;
    logic [CNT_W-1:0]    n_failed_sweeps;

    logic [SEGSUM_W:0]   w_seg_add;
    logic [PACK_W:0]     w_pack_add;
    logic                w_take_low;
    logic                w_take_high;

    assign w_take_low  = r_at_start || (i_item.voltage < r_low_value);
    assign w_take_high = r_at_start || (i_item.voltage > r_high_value);
    assign w_seg_add   = {1'b0, r_segment_sum} + (SEGSUM_W+1)'(i_item.voltage);
    assign w_pack_add  = {1'b0, r_pack_sum} + (PACK_W+1)'(i_item.voltage);

    always_comb begin
        n_low_value    = w_take_low  ? i_item.voltage  : r_low_value;
        n_low_segment  = w_take_low  ? i_item.segment  : r_low_segment;
        n_low_cell     = w_take_low  ? i_item.cell_req : r_low_cell;
        n_high_value   = w_take_high ? i_item.voltage  : r_high_value;
        n_high_segment = w_take_high ? i_item.segment  : r_high_segment;
        n_high_cell    = w_take_high ? i_item.cell_req : r_high_cell;
        n_segment_sum  = w_seg_add[SEGSUM_W] ? SEGSUM_MAX : w_seg_add[SEGSUM_W-1:0];
        n_pack_sum     = w_pack_add[PACK_W] ? PACK_MAX : w_pack_add[PACK_W-1:0];
        n_had_failure  = r_had_failure || !i_item.read_ok;
        if (!n_had_failure) begin
            n_failed_sweeps = '0;
        end else if (r_failed_sweeps == CNT_MAX) begin
            n_failed_sweeps = CNT_MAX;
        end else begin
            n_failed_sweeps = r_failed_sweeps + 1'b1;
        end
    end

    assign o_has_result = i_item.segment_last || i_item.sweep_last;

    always_comb begin
        o_result                 = '0;
        o_result.segment_index   = i_item.segment;
        o_result.segment_voltage = n_segment_sum[SEGSUM_W-1] ? SEGOUT_MAX
                                                             : n_segment_sum[SEGOUT_W-1:0];
        if (i_item.sweep_last) begin
            o_result.sweep_done   = 1'b1;
            o_result.pack_total   = n_pack_sum;
            o_result.min_voltage  = n_low_value;
            o_result.min_segment  = n_low_segment;
            o_result.min_cell     = n_low_cell;
            o_result.max_voltage  = n_high_value;
            o_result.max_segment  = n_high_segment;
            o_result.max_cell     = n_high_cell;
            o_result.fail_count   = n_failed_sweeps;
            o_result.comm_fault   = n_failed_sweeps >= i_fail_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_value     <= '0;
            r_low_segment   <= '0;
            r_low_cell      <= '0;
            r_high_value    <= '0;
            r_high_segment  <= '0;
            r_high_cell     <= '0;
            r_segment_sum   <= '0;
            r_pack_sum      <= '0;
            r_had_failure   <= 1'b0;
            r_failed_sweeps <= '0;
            r_at_start      <= 1'b1;
        end else if (i_fire) begin
            r_low_value    <= n_low_value;
            r_low_segment  <= n_low_segment;
            r_low_cell     <= n_low_cell;
            r_high_value   <= n_high_value;
            r_high_segment <= n_high_segment;
            r_high_cell    <= n_high_cell;
            r_segment_sum  <= o_has_result ? '0 : n_segment_sum;
            r_at_start     <= i_item.sweep_last;
            if (i_item.sweep_last) begin
                r_pack_sum      <= '0;
                r_had_failure   <= 1'b0;
                r_failed_sweeps <= n_failed_sweeps;
            end else begin
                r_pack_sum    <= n_pack_sum;
                r_had_failure <= n_had_failure;
            end
        end
    end

endmodule

/* rtl/core/cvs_out_stage.sv */
module cvs_out_stage import cvs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_stat_item i_item,
    input  logic       i_ready,
    output logic       o_free,
    output logic       o_valid,
    output t_stat_item o_item
);

    logic       r_valid;
    t_stat_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/core/cell_voltage_statistics_core.sv */
// an input transfer goes through the input register, then the result register, to o_stat
// throughput: one cell per cycle unless a result waits on o_stat; min/max and sums are combinational
// items that close neither a segment nor a sweep give no result and never wait on o_stat
// reset: i_rst_n synchronous active low, clears both stages, all statistics and the fail count
// fail_limit returns to 3 on reset; no clearing pass, the block takes items right after reset
module cell_voltage_statistics_core import cvs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cvs_cell_if.sink         i_cell,
    cvs_stat_if.source       o_stat,
    input  logic             i_fail_limit_we,
    input  logic [CNT_W-1:0] i_fail_limit
);

    logic [CNT_W-1:0] r_fail_limit;
    t_cell_item       w_in_item;
    t_cell_item       w_cur_item;
    t_stat_item       w_result;
    t_stat_item       w_out_item;
    t_stage_ctl       w_ctl;
    logic             w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit <= FAIL_LIMIT_RESET;
        end else if (i_fail_limit_we) begin
            r_fail_limit <= i_fail_limit;
        end
    end

    assign w_in_item.voltage      = i_cell.voltage;
    assign w_in_item.segment      = i_cell.segment;
    assign w_in_item.cell_req     = i_cell.cell_req;
    assign w_in_item.read_ok      = i_cell.read_ok;
    assign w_in_item.segment_last = i_cell.segment_last;
    assign w_in_item.sweep_last   = i_cell.sweep_last;

    assign w_ctl.advance = w_ctl.valid && (!w_ctl.has_result || w_out_free);

    cvs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cell.valid),
        .i_item    (w_in_item),
        .i_advance (w_ctl.advance),
        .o_ready   (i_cell.ready),
        .o_valid   (w_ctl.valid),
        .o_item    (w_cur_item)
    );

    cvs_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_ctl.advance),
        .i_item       (w_cur_item),
        .i_fail_limit (r_fail_limit),
        .o_has_result (w_ctl.has_result),
        .o_result     (w_result)
    );

    cvs_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ctl.advance && w_ctl.has_result),
        .i_item  (w_result),
        .i_ready (o_stat.ready),
        .o_free  (w_out_free),
        .o_valid (o_stat.valid),
        .o_item  (w_out_item)
    );

    assign o_stat.segment_index   = w_out_item.segment_index;
    assign o_stat.segment_voltage = w_out_item.segment_voltage;
    assign o_stat.sweep_done      = w_out_item.sweep_done;
    assign o_stat.pack_total      = w_out_item.pack_total;
    assign o_stat.min_voltage     = w_out_item.min_voltage;
    assign o_stat.min_segment     = w_out_item.min_segment;
    assign o_stat.min_cell        = w_out_item.min_cell;
    assign o_stat.max_voltage     = w_out_item.max_voltage;
    assign o_stat.max_segment     = w_out_item.max_segment;
    assign o_stat.max_cell        = w_out_item.max_cell;
    assign o_stat.fail_count      = w_out_item.fail_count;
    assign o_stat.comm_fault      = w_out_item.comm_fault;

    a_result_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.advance && w_ctl.has_result) |-> (!o_stat.valid || o_stat.ready))
        else $error("result loaded over a pending transfer");

    a_segment_only_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.valid && !o_stat.sweep_done) |->
            (o_stat.pack_total == '0 && o_stat.fail_count == '0 && !o_stat.comm_fault))
        else $error("segment result carries sweep fields");

    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.valid && !w_ctl.advance) |-> !i_cell.ready)
        else $error("input taken while held item is stalled");

endmodule

/* dv/tb_cell_voltage_statistics_core.sv */
`timescale 1ns / 1ps

module tb_cell_voltage_statistics_core;
    import cvs_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 120;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_limit;

    cvs_cell_if cell_bus ();
    cvs_stat_if stat_bus ();

    cell_voltage_statistics_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cell          (cell_bus),
        .o_stat          (stat_bus),
        .i_fail_limit_we (cfg_we),
        .i_fail_limit    (cfg_limit)
    );

    t_cell_item cell_q[$];
    t_cell_item cell_cur;
    t_stat_item stat_expect[$];
    t_stat_item stat_seen;

    assign stat_seen = {stat_bus.segment_index, stat_bus.segment_voltage, stat_bus.sweep_done,
                        stat_bus.pack_total, stat_bus.min_voltage, stat_bus.min_segment,
                        stat_bus.min_cell, stat_bus.max_voltage, stat_bus.max_segment,
                        stat_bus.max_cell, stat_bus.fail_count, stat_bus.comm_fault};

    // predictor state, matches the block after reset
    logic [VOLT_W-1:0]   lo_volt = '0;
    logic [SEG_W-1:0]    lo_seg = '0;
    logic [CELL_W-1:0]   lo_idx = '0;
    logic [VOLT_W-1:0]   hi_volt = '0;
    logic [SEG_W-1:0]    hi_seg = '0;
    logic [CELL_W-1:0]   hi_idx = '0;
    logic [SEGSUM_W-1:0] seg_acc = '0;
    logic [PACK_W-1:0]   pack_acc = '0;
    logic                sweep_failed = 1'b0;
    logic [CNT_W-1:0]    fail_run = '0;
    logic                sweep_fresh = 1'b1;
    logic [CNT_W-1:0]    limit_copy = FAIL_LIMIT_RESET;

    int sender_idle_pct = 33;
    int sink_idle_pct = 33;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void track_cell_stats(t_cell_item c);
        logic [SEGSUM_W:0] seg_next;
        logic [PACK_W:0]   pack_next;
        t_stat_item        r;
        if (sweep_fresh) begin
            lo_volt = c.voltage;
            lo_seg = c.segment;
            lo_idx = c.cell_req;
            hi_volt = c.voltage;
            hi_seg = c.segment;
            hi_idx = c.cell_req;
            sweep_fresh = 1'b0;
        end else begin
            if (c.voltage < lo_volt) begin
                lo_volt = c.voltage;
                lo_seg = c.segment;
                lo_idx = c.cell_req;
            end
            if (c.voltage > hi_volt) begin
                hi_volt = c.voltage;
                hi_seg = c.segment;
                hi_idx = c.cell_req;
            end
        end
        seg_next = seg_acc + c.voltage;
        seg_acc = (seg_next > SEGSUM_MAX) ? SEGSUM_MAX : seg_next[SEGSUM_W-1:0];
        pack_next = pack_acc + c.voltage;
        pack_acc = (pack_next > PACK_MAX) ? PACK_MAX : pack_next[PACK_W-1:0];
        if (!c.read_ok) begin
            sweep_failed = 1'b1;
        end
        if (c.segment_last || c.sweep_last) begin
            r = '0;
            r.segment_index = c.segment;
            r.segment_voltage = (seg_acc > SEGOUT_MAX) ? SEGOUT_MAX : seg_acc[SEGOUT_W-1:0];
            seg_acc = '0;
            if (c.sweep_last) begin
                if (sweep_failed) begin
                    if (fail_run != CNT_MAX) begin
                        fail_run = fail_run + 1'b1;
                    end
                end else begin
                    fail_run = '0;
                end
                r.sweep_done = 1'b1;
                r.pack_total = pack_acc;
                r.min_voltage = lo_volt;
                r.min_segment = lo_seg;
                r.min_cell = lo_idx;
                r.max_voltage = hi_volt;
                r.max_segment = hi_seg;
                r.max_cell = hi_idx;
                r.fail_count = fail_run;
                r.comm_fault = (fail_run >= limit_copy);
                pack_acc = '0;
                sweep_failed = 1'b0;
                sweep_fresh = 1'b1;
            end
            stat_expect.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void push_cell(logic [VOLT_W-1:0] v, logic [SEG_W-1:0] seg,
                                      logic [CELL_W-1:0] idx, bit ok, bit seg_end,
                                      bit sweep_end);
        t_cell_item c;
        c.voltage = v;
        c.segment = seg;
        c.cell_req = idx;
        c.read_ok = ok;
        c.segment_last = seg_end;
        c.sweep_last = sweep_end;
        cell_q.push_back(c);
    endfunction

    function automatic logic [VOLT_W-1:0] rand_volt(bit narrow);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return narrow ? VOLT_W'($urandom_range(40000, 40003)) : VOLT_W'($urandom);
        endcase
    endfunction

    function automatic int push_sweep(int nseg, int cmax, bit failing);
        int               ncell;
        int               total;
        bit               narrow;
        bit               drop_seg_end;
        bit               bad_seen;
        bit               ok;
        bit               last_seg;
        bit               last_one;
        logic [SEG_W-1:0] seg_base;
        total = 0;
        narrow = ($urandom_range(3) == 0);
        drop_seg_end = ($urandom_range(3) == 0);
        bad_seen = 1'b0;
        seg_base = SEG_W'($urandom);
        for (int s = 0; s < nseg; s++) begin
            ncell = $urandom_range(1, cmax);
            for (int c = 0; c < ncell; c++) begin
                last_seg = (c == ncell - 1);
                last_one = last_seg && (s == nseg - 1);
                ok = !(failing && ($urandom_range(3) == 0 || (last_one && !bad_seen)));
                bad_seen = bad_seen || !ok;
                push_cell(rand_volt(narrow), SEG_W'(seg_base + s), CELL_W'(c), ok,
                          last_seg && !(last_one && drop_seg_end), last_one);
                total++;
            end
        end
        return total;
    endfunction

    task automatic fill_random(int target);
        int pushed;
        int nseg;
        int cmax;
        pushed = 0;
        while (pushed < target) begin
            if ($urandom_range(99) < 85) begin
                nseg = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
                cmax = ($urandom_range(9) == 0) ? 16 : 4;
                pushed += push_sweep(nseg, cmax, $urandom_range(99) < 40);
            end else begin
                push_cell(rand_volt(1'b0), SEG_W'($urandom), CELL_W'($urandom),
                          $urandom_range(3) != 0, $urandom_range(2) == 0,
                          $urandom_range(5) == 0);
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cell_q.size() != 0 || cell_bus.valid || stat_expect.size() != 0);
        // items without a result may still sit in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_limit <= value;
        limit_copy = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_bus.valid <= 1'b0;
        end else begin
            if (cell_bus.valid && cell_bus.ready) begin
                track_cell_stats(cell_cur);
            end
            if (!cell_bus.valid || cell_bus.ready) begin
                if (cell_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cell_cur = cell_q.pop_front();
                    cell_bus.valid <= 1'b1;
                    cell_bus.voltage <= cell_cur.voltage;
                    cell_bus.segment <= cell_cur.segment;
                    cell_bus.cell_req <= cell_cur.cell_req;
                    cell_bus.read_ok <= cell_cur.read_ok;
                    cell_bus.segment_last <= cell_cur.segment_last;
                    cell_bus.sweep_last <= cell_cur.sweep_last;
                end else begin
                    cell_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_stat_item want;
        if (!i_rst_n) begin
            stat_bus.ready <= 1'b0;
        end else begin
            if (stat_bus.valid && stat_bus.ready) begin
                if (stat_expect.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none actual %h",
                             $time, stat_seen);
                    error_count++;
                end else begin
                    want = stat_expect.pop_front();
                    check_field("segment_index", want.segment_index, stat_seen.segment_index);
                    check_field("segment_voltage", want.segment_voltage,
                                stat_seen.segment_voltage);
                    check_field("sweep_done", want.sweep_done, stat_seen.sweep_done);
                    check_field("pack_total", want.pack_total, stat_seen.pack_total);
                    check_field("min_voltage", want.min_voltage, stat_seen.min_voltage);
                    check_field("min_segment", want.min_segment, stat_seen.min_segment);
                    check_field("min_cell", want.min_cell, stat_seen.min_cell);
                    check_field("max_voltage", want.max_voltage, stat_seen.max_voltage);
                    check_field("max_segment", want.max_segment, stat_seen.max_segment);
                    check_field("max_cell", want.max_cell, stat_seen.max_cell);
                    check_field("fail_count", want.fail_count, stat_seen.fail_count);
                    check_field("comm_fault", want.comm_fault, stat_seen.comm_fault);
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                stat_bus.ready <= 1'b0;
            end else begin
                stat_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_bus.valid && cell_bus.ready)
                || (stat_bus.valid && stat_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_limit = '0;
        cell_bus.valid = 1'b0;
        cell_bus.voltage = '0;
        cell_bus.segment = '0;
        cell_bus.cell_req = '0;
        cell_bus.read_ok = 1'b0;
        cell_bus.segment_last = 1'b0;
        cell_bus.sweep_last = 1'b0;
        stat_bus.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items, fail limit at its reset value
        @(negedge i_clk);
        push_cell(16'h0000, 3'd7, 4'd15, 1'b1, 1'b1, 1'b1);
        push_cell(16'hFFFF, 3'd0, 4'd0, 1'b1, 1'b1, 1'b1);
        // equal codes later in the sweep keep the first location
        push_cell(16'd500, 3'd2, 4'd0, 1'b1, 1'b0, 1'b0);
        push_cell(16'd500, 3'd2, 4'd1, 1'b1, 1'b0, 1'b0);
        push_cell(16'd300, 3'd2, 4'd2, 1'b1, 1'b0, 1'b0);
        push_cell(16'd900, 3'd2, 4'd3, 1'b1, 1'b0, 1'b0);
        push_cell(16'd300, 3'd2, 4'd4, 1'b1, 1'b0, 1'b0);
        push_cell(16'd900, 3'd2, 4'd5, 1'b1, 1'b1, 1'b0);
        push_cell(16'd300, 3'd5, 4'd0, 1'b1, 1'b0, 1'b0);
        // sweep end closes the open segment
        push_cell(16'd900, 3'd5, 4'd9, 1'b1, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++) begin
            push_cell(rand_volt(1'b0), 3'd1, 4'd3, 1'b0, 1'b1, 1'b1);
        end
        push_cell(16'd1234, 3'd4, 4'd8, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // overlong segments saturate the segment and pack sums
        write_limit(8'd1);
        @(negedge i_clk);
        for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < 43; c++) begin
                push_cell(16'hFFFF, SEG_W'(s), CELL_W'(c), !(s == 1 && c == 7),
                          c == 42, s == 2 && c == 42);
            end
        end
        wait_drained();

        // fail count runs into saturation, first with no idling
        write_limit(8'd255);
        @(negedge i_clk);
        sender_idle_pct = 0;
        sink_idle_pct = 0;
        for (int k = 0; k < 128; k++) begin
            push_cell(rand_volt(1'b0), SEG_W'($urandom), CELL_W'($urandom), 1'b0, 1'b1, 1'b1);
        end
        wait_drained();

        // then under a long receiver hold
        sender_idle_pct = 33;
        sink_idle_pct = 33;
        hold_armed = 1'b1;
        for (int k = 0; k < 128; k++) begin
            push_cell(rand_volt(1'b0), SEG_W'($urandom), CELL_W'($urandom), 1'b0, 1'b1, 1'b1);
        end
        wait_drained();

        write_limit(8'd0);
        @(negedge i_clk);
        void'(push_sweep(2, 4, 1'b0));
        void'(push_sweep(1, 1, 1'b1));
        void'(push_sweep(2, 4, 1'b0));
        wait_drained();

        for (int ph = 0; ph < 2; ph++) begin
            write_limit(CNT_W'($urandom_range(1, 4)));
            @(negedge i_clk);
            fill_random(30);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/cvs_pkg.sv
rtl/core/cvs_cell_if.sv
rtl/core/cvs_stat_if.sv
rtl/core/cvs_in_stage.sv
rtl/core/cvs_tracker.sv
rtl/core/cvs_out_stage.sv
rtl/core/cell_voltage_statistics_core.sv
dv/tb_cell_voltage_statistics_core.sv
